// File: rtl/mrc_pkg.sv
// Package for the multichannel ray collator: item structs, slot entry type,
// result kind and command codes and sizing constants. No dependencies.
package mrc_pkg;

    localparam int SLOTS       = 8;
    localparam int CHANNELS    = 4;
    localparam int HANDLE_BITS = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CH_W        = $clog2(CHANNELS);

    localparam logic [2:0] K_COLLATED = 3'd0;
    localparam logic [2:0] K_DISCARD  = 3'd1;
    localparam logic [2:0] K_RADAR    = 3'd2;
    localparam logic [2:0] K_CHANNEL  = 3'd3;
    localparam logic [2:0] K_COUNT    = 3'd4;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [HANDLE_BITS-1:0] t_hnd;

    typedef struct packed {
        logic        command;
        logic [7:0]  ray_radar;
        logic [2:0]  channel;
        logic [31:0] ray_number;
        logic [15:0] ray_handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_handle;
        logic [31:0] out_ray_number;
        logic [2:0]  out_channel;
        logic [15:0] discard_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0]                 key;
        logic [CHANNELS-1:0]         present;
        t_hnd [CHANNELS-1:0]         handles;
    } t_ent;

endpackage

// File: rtl/multichannel_ray_collator.sv
// Multichannel ray collator: slot table in mrc_ram, sequencer and output register.
// Steps: a rejected ray or count report goes through S_OUT1 into the output register;
// an add scans the table (S_SCAN, S_DEC) and updates it in S_UPD. A completed set
// rescans, flushes each lower set in S_DROP and rescans again, then releases its
// channels in S_COL; an eviction flushes the lowest set first. Output stalls hold these.
// One item at a time; the input stalls until the item is done. Reset (synchronous,
// active low) clears slot valid bits, discard count, radar id, output valid and state.
module multichannel_ray_collator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mrc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mrc_pkg::t_out_item  o_out_item
);
    import mrc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OUT1 = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_DROP = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_COL  = 3'd6;

    logic [2:0]        r_state;
    logic [7:0]        r_radar;
    logic [15:0]       r_cnt;
    logic [SLOTS-1:0]  r_valid;
    t_in_item          r_item;
    logic [2:0]        r_okind;
    logic              r_ov;
    t_out_item         r_out;

    // scan
    logic [SLOT_W:0]   r_iss;
    logic              r_pv;
    logic [SLOT_W-1:0] r_pidx;
    logic              r_lim;
    logic              r_fnd_v, r_best_v, r_free_v;
    logic [SLOT_W-1:0] r_fnd_idx, r_best_idx, r_free_idx;
    t_ent              r_fnd_ent, r_best_ent;

    // work
    t_ent              r_ent, r_col;
    logic [SLOT_W-1:0] r_d, r_f;
    logic              r_evict;
    logic [CH_W-1:0]   r_ch;

    logic              out_free, in_acc;
    logic              ov_load;
    logic [CH_W-1:0]   in_c;
    logic              chan_ok;
    logic [$bits(t_ent)-1:0] rd_raw;
    t_ent              rd_ent, blank, n_col;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic              more_above;

    assign out_free = !r_ov || !i_out_stall;
    assign ov_load = out_free && ((r_state == S_OUT1) || (r_state == S_COL)
                     || (r_state == S_DROP && r_ent.present[r_ch]));
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out_item = r_out;
    assign in_c = CH_W'(r_item.channel - 3'd1);
    assign chan_ok = (i_in_item.channel >= 3'd1) && (32'(i_in_item.channel) <= CHANNELS);
    assign rd_ent = t_ent'(rd_raw);
    assign raddr = r_iss[SLOT_W-1:0];
    assign we = (r_state == S_UPD);

    always_comb begin
        blank = '0;
        blank.key = r_item.ray_number;
        n_col = r_col;
        n_col.present[in_c] = 1'b1;
        n_col.handles[in_c] = t_hnd'(r_item.ray_handle);
        more_above = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (c > 32'(r_ch) && r_ent.present[c]) more_above = 1'b1;
        end
    end

    mrc_ram #(.WIDTH($bits(t_ent)), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_f),
        .i_wdata (n_col),
        .i_raddr (raddr),
        .o_rdata (rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radar <= '0;
            r_cnt   <= '0;
            r_valid <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            if (i_cfg_we) r_radar <= i_cfg_wdata;
            if (r_ov && !i_out_stall && !ov_load) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_in_item;
                        if (i_in_item.command == CMD_READ) begin
                            r_okind <= K_COUNT;
                            r_state <= S_OUT1;
                        end else if (i_in_item.ray_radar != r_radar) begin
                            r_okind <= K_RADAR;
                            r_state <= S_OUT1;
                        end else if (!chan_ok) begin
                            r_okind <= K_CHANNEL;
                            r_state <= S_OUT1;
                        end else begin
                            r_lim <= 1'b0;
                            r_iss <= '0;
                            r_pv <= 1'b0;
                            r_fnd_v <= 1'b0;
                            r_best_v <= 1'b0;
                            r_free_v <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_OUT1: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_out.kind <= r_okind;
                        r_out.last <= 1'b1;
                        if (r_okind == K_COUNT) begin
                            r_out.out_handle <= '0;
                            r_out.out_ray_number <= '0;
                            r_out.out_channel <= '0;
                            r_out.discard_count <= r_cnt;
                            r_cnt <= '0;
                        end else begin
                            r_out.out_handle <= 16'(t_hnd'(r_item.ray_handle));
                            r_out.out_ray_number <= r_item.ray_number;
                            r_out.out_channel <= r_item.channel;
                            r_out.discard_count <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (32'(r_iss) < SLOTS) r_iss <= r_iss + 1'b1;
                    r_pv <= (32'(r_iss) < SLOTS);
                    r_pidx <= raddr;
                    if (r_pv) begin
                        if (!r_valid[r_pidx] && !r_free_v) begin
                            r_free_v <= 1'b1;
                            r_free_idx <= r_pidx;
                        end
                        if (r_valid[r_pidx] && rd_ent.key == r_item.ray_number && !r_fnd_v) begin
                            r_fnd_v <= 1'b1;
                            r_fnd_idx <= r_pidx;
                            r_fnd_ent <= rd_ent;
                        end
                        if (r_valid[r_pidx] && (!r_lim || rd_ent.key < r_item.ray_number)
                            && (!r_best_v || rd_ent.key < r_best_ent.key)) begin
                            r_best_v <= 1'b1;
                            r_best_idx <= r_pidx;
                            r_best_ent <= rd_ent;
                        end
                        if (32'(r_pidx) == SLOTS - 1) r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_ch <= '0;
                    if (r_lim) begin
                        if (r_best_v) begin
                            r_ent <= r_best_ent;
                            r_d <= r_best_idx;
                            r_evict <= 1'b0;
                            r_state <= S_DROP;
                        end else begin
                            r_state <= S_COL;
                        end
                    end else if (r_fnd_v && r_fnd_ent.present[in_c]) begin
                        r_okind <= K_CHANNEL;
                        r_state <= S_OUT1;
                    end else if (r_fnd_v) begin
                        r_col <= r_fnd_ent;
                        r_f <= r_fnd_idx;
                        r_state <= S_UPD;
                    end else if (r_free_v) begin
                        r_col <= blank;
                        r_f <= r_free_idx;
                        r_state <= S_UPD;
                    end else begin
                        // table full: evict the lowest set first
                        r_col <= blank;
                        r_f <= r_best_idx;
                        r_d <= r_best_idx;
                        r_ent <= r_best_ent;
                        r_evict <= 1'b1;
                        r_state <= S_DROP;
                    end
                end
                S_DROP: begin
                    if (!r_ent.present[r_ch] || out_free) begin
                        if (r_ent.present[r_ch]) begin
                            r_ov <= 1'b1;
                            r_out.kind <= K_DISCARD;
                            r_out.out_handle <= 16'(r_ent.handles[r_ch]);
                            r_out.out_ray_number <= r_ent.key;
                            r_out.out_channel <= 3'(r_ch) + 3'd1;
                            r_out.discard_count <= '0;
                            r_out.last <= r_evict && !more_above;
                            if (r_cnt != 16'hFFFF) r_cnt <= r_cnt + 16'd1;
                        end
                        r_ch <= r_ch + 1'b1;
                        if (32'(r_ch) == CHANNELS - 1) begin
                            r_valid[r_d] <= 1'b0;
                            if (r_evict) begin
                                r_state <= S_UPD;
                            end else begin
                                r_iss <= '0;
                                r_pv <= 1'b0;
                                r_best_v <= 1'b0;
                                r_fnd_v <= 1'b0;
                                r_free_v <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_UPD: begin
                    r_valid[r_f] <= 1'b1;
                    r_col <= n_col;
                    if (&n_col.present) begin
                        // flush every lower set before release
                        r_lim <= 1'b1;
                        r_iss <= '0;
                        r_pv <= 1'b0;
                        r_best_v <= 1'b0;
                        r_fnd_v <= 1'b0;
                        r_free_v <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_COL: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_out.kind <= K_COLLATED;
                        r_out.out_handle <= 16'(r_col.handles[r_ch]);
                        r_out.out_ray_number <= r_col.key;
                        r_out.out_channel <= 3'(r_ch) + 3'd1;
                        r_out.discard_count <= '0;
                        r_out.last <= (32'(r_ch) == CHANNELS - 1);
                        r_ch <= r_ch + 1'b1;
                        if (32'(r_ch) == CHANNELS - 1) begin
                            r_valid[r_f] <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_col_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (&r_col.present))
        else $error("release of an incomplete set");

    a_drop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROP) |-> r_valid[r_d])
        else $error("flush of a free slot");

    a_cmd_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.command == CMD_READ) |=> (r_state == S_OUT1 && r_okind == K_COUNT))
        else $error("count command not reported");
endmodule

// File: rtl/mrc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
